/* rtl/tccw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, types and helpers of the text console cell writer:
// screen geometry, field widths, opcodes, control characters.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int FILL_BASE  = (ROWS - 1) * COLUMNS;

  // Cell index into the store, and a pointer that can also hold CELL_COUNT
  localparam int IDX_W = $clog2(CELL_COUNT);
  localparam int PTR_W = $clog2(CELL_COUNT + 1);

  // Fixed field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int ENTRY_W = 16;

  // Cursor arithmetic widths: one bit of headroom over the stored cursor
  localparam int CX_W = COL_W + 1;
  localparam int RX_W = ROW_W + 1;

  localparam logic [ENTRY_W-1:0] RESET_ENTRY = 16'h0720;
  localparam logic [ATTR_W-1:0]  RESET_ATTR  = 8'h07;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;

  // Control characters and the printable range
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;
  localparam logic [CX_W-1:0]   TAB_STEP   = 8'd8;
  localparam logic [CX_W-1:0]   TAB_MASK   = ~8'd7;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Cursor update of one put-character request
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             written;
    logic             scroll;
  } cursor_upd_t;

  // Linear base of a row
  function automatic logic [PTR_W-1:0] row_base(input logic [ROW_W-1:0] r);
    return PTR_W'(int'(r) * COLUMNS);
  endfunction

endpackage

/* rtl/tccw_screen_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_screen_ram
// Screen cell store: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tccw_screen_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [tccw_pkg::IDX_W-1:0]    wr_addr,
  input  logic [tccw_pkg::ENTRY_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [tccw_pkg::IDX_W-1:0]    rd_addr,
  output logic [tccw_pkg::ENTRY_W-1:0]  rd_data
);

  logic [tccw_pkg::ENTRY_W-1:0] mem [tccw_pkg::CELL_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tccw_cursor_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_cursor_step
// Cursor movement for one put-character request: control characters,
// printable store and advance, line wrap and the need to scroll.
// ----------------------------------------------------------------------------
module tccw_cursor_step (
  input  logic [tccw_pkg::COL_W-1:0]  cur_col,
  input  logic [tccw_pkg::ROW_W-1:0]  cur_row,
  input  logic [tccw_pkg::CHAR_W-1:0] char_code,
  output tccw_pkg::cursor_upd_t       upd
);

  logic [tccw_pkg::CX_W-1:0] col_x;
  logic [tccw_pkg::RX_W-1:0] row_x;
  logic [tccw_pkg::CX_W-1:0] tab_col;
  logic [tccw_pkg::CX_W-1:0] cols_x;
  logic [tccw_pkg::RX_W-1:0] rows_x;
  logic                      printable;

  assign cols_x    = tccw_pkg::CX_W'(tccw_pkg::COLUMNS);
  assign rows_x    = tccw_pkg::RX_W'(tccw_pkg::ROWS);
  assign tab_col   = (tccw_pkg::CX_W'(cur_col) + tccw_pkg::TAB_STEP) & tccw_pkg::TAB_MASK;
  assign printable = (char_code >= tccw_pkg::PRINT_LO) && (char_code <= tccw_pkg::PRINT_HI);

  // Move the cursor by character class
  always_comb begin
    col_x       = tccw_pkg::CX_W'(cur_col);
    row_x       = tccw_pkg::RX_W'(cur_row);
    upd.written = 1'b0;
    priority if (char_code == tccw_pkg::CH_LF) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end else if (char_code == tccw_pkg::CH_CR) begin
      col_x = '0;
    end else if (char_code == tccw_pkg::CH_TAB) begin
      if (tab_col >= cols_x) begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end else begin
        col_x = tab_col;
      end
    end else if (char_code == tccw_pkg::CH_BS) begin
      if (cur_col != '0) begin
        col_x = col_x - 1'b1;
      end else if (cur_row != '0) begin
        row_x = row_x - 1'b1;
        col_x = cols_x - 1'b1;
      end
    end else if (printable) begin
      upd.written = 1'b1;
      col_x       = col_x + 1'b1;
      if (col_x >= cols_x) begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
    end else begin
      col_x = tccw_pkg::CX_W'(cur_col);
    end

    // Past the last row: stay on it and scroll
    upd.scroll = (row_x >= rows_x);
    if (upd.scroll) begin
      row_x = rows_x - 1'b1;
    end
    upd.col = col_x[tccw_pkg::COL_W-1:0];
    upd.row = row_x[tccw_pkg::ROW_W-1:0];
  end

endmodule

/* rtl/text_console_cell_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Character-cell text console: screen store, cursor and a small sequencer
// that drives one shared address adder and the store's single port pair.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all CELL_COUNT cells (2000 at
// 80x25) that fills the screen with 0x0720 and holds in_stall high; the
// attribute register can be written meanwhile. A scroll copies the screen
// up one row through the store's one read and one write port, then blanks
// the bottom row. Clear screen writes one cell a cycle. Each request gives
// one result, held in an output register; a new request is taken while it
// waits.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [tccw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tccw_pkg::COL_W-1:0]    col,
  input  logic [tccw_pkg::ROW_W-1:0]    row,
  // Attribute register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tccw_pkg::ATTR_W-1:0]   text_attribute,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tccw_pkg::COL_W-1:0]    cursor_col,
  output logic [tccw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tccw_pkg::POS_W-1:0]    cursor_pos,
  output logic                          cell_written,
  output logic [tccw_pkg::POS_W-1:0]    cell_index,
  output logic [tccw_pkg::ENTRY_W-1:0]  cell_entry,
  output logic                          scrolled,
  output logic [tccw_pkg::ENTRY_W-1:0]  read_entry
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                        state;
  logic [tccw_pkg::ATTR_W-1:0]   attr;
  logic [tccw_pkg::COL_W-1:0]    cur_col;
  logic [tccw_pkg::ROW_W-1:0]    cur_row;

  // Latched request
  tccw_pkg::op_t                 op_q;
  logic [tccw_pkg::CHAR_W-1:0]   ch_q;
  logic [tccw_pkg::COL_W-1:0]    col_q;
  logic [tccw_pkg::ROW_W-1:0]    row_q;

  // Sweep pointers
  logic [tccw_pkg::PTR_W-1:0]    rptr;
  logic [tccw_pkg::PTR_W-1:0]    wptr;
  logic                          copy_v;

  // Result in progress
  logic                          res_written;
  logic [tccw_pkg::POS_W-1:0]    res_index;
  logic [tccw_pkg::ENTRY_W-1:0]  res_entry;
  logic                          res_scrolled;
  logic [tccw_pkg::ENTRY_W-1:0]  res_read;

  // Shared address adder
  logic [tccw_pkg::PTR_W-1:0]    add_a;
  logic [tccw_pkg::PTR_W-1:0]    add_b;
  logic [tccw_pkg::PTR_W-1:0]    add_sum;

  // Store ports
  logic                          wr_en;
  logic [tccw_pkg::IDX_W-1:0]    wr_addr;
  logic [tccw_pkg::ENTRY_W-1:0]  wr_data;
  logic                          rd_en;
  logic [tccw_pkg::IDX_W-1:0]    rd_addr;
  logic [tccw_pkg::ENTRY_W-1:0]  rd_data;

  tccw_pkg::cursor_upd_t         upd;
  logic                          in_accept;
  logic                          out_free;
  logic                          req_in_range;
  logic [tccw_pkg::ENTRY_W-1:0]  blank;

  assign in_stall     = (state != S_IDLE);
  assign in_accept    = in_valid && (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_free     = !out_valid || !out_stall;
  assign req_in_range = (int'(col_q) < tccw_pkg::COLUMNS) && (int'(row_q) < tccw_pkg::ROWS);
  assign blank        = {attr, tccw_pkg::BLANK_CHAR};

  tccw_cursor_step u_cursor (
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .char_code (ch_q),
    .upd       (upd)
  );

  tccw_screen_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Select the adder operands by step
  always_comb begin
    unique case (state)
      S_EXEC: begin
        if (op_q == tccw_pkg::OP_READ) begin
          add_a = tccw_pkg::row_base(row_q);
          add_b = tccw_pkg::PTR_W'(col_q);
        end else begin
          add_a = tccw_pkg::row_base(cur_row);
          add_b = tccw_pkg::PTR_W'(cur_col);
        end
      end
      S_SCROLL: begin
        add_a = rptr;
        add_b = tccw_pkg::PTR_W'(1);
      end
      S_DONE: begin
        add_a = tccw_pkg::row_base(cur_row);
        add_b = tccw_pkg::PTR_W'(cur_col);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // Drive the store ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[tccw_pkg::IDX_W-1:0];
    wr_data = blank;
    rd_en   = 1'b0;
    rd_addr = rptr[tccw_pkg::IDX_W-1:0];
    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = tccw_pkg::RESET_ENTRY;
      end
      S_EXEC: begin
        if (op_q == tccw_pkg::OP_PUT) begin
          wr_en   = upd.written;
          wr_addr = add_sum[tccw_pkg::IDX_W-1:0];
          wr_data = {attr, ch_q};
        end else if (op_q == tccw_pkg::OP_READ) begin
          rd_en   = req_in_range;
          rd_addr = add_sum[tccw_pkg::IDX_W-1:0];
        end
      end
      S_SCROLL: begin
        wr_en   = copy_v;
        wr_data = rd_data;
        rd_en   = (int'(rptr) < tccw_pkg::CELL_COUNT);
      end
      S_FILL: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tccw_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      attr <= text_attribute;
    end
  end

  // Sequencer, cursor and sweep pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cur_col <= '0;
      cur_row <= '0;
      wptr    <= '0;
      rptr    <= '0;
      copy_v  <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (int'(wptr) == tccw_pkg::CELL_COUNT - 1) begin
            state <= S_IDLE;
          end
          wptr <= wptr + 1'b1;
        end
        S_IDLE: begin
          if (in_accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_q)
            tccw_pkg::OP_PUT: begin
              cur_col <= upd.col;
              cur_row <= upd.row;
              if (upd.scroll) begin
                rptr   <= tccw_pkg::PTR_W'(tccw_pkg::COLUMNS);
                wptr   <= '0;
                copy_v <= 1'b0;
                state  <= S_SCROLL;
              end else begin
                state <= S_DONE;
              end
            end
            tccw_pkg::OP_SET: begin
              if (req_in_range) begin
                cur_col <= col_q;
                cur_row <= row_q;
              end
              state <= S_DONE;
            end
            tccw_pkg::OP_CLEAR: begin
              cur_col <= '0;
              cur_row <= '0;
              wptr    <= '0;
              state   <= S_FILL;
            end
            tccw_pkg::OP_READ: begin
              state <= req_in_range ? S_READ : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_SCROLL: begin
          // Advance the write side behind the read side, through the registered read data
          if (copy_v) begin
            wptr <= wptr + 1'b1;
          end
          if (int'(rptr) < tccw_pkg::CELL_COUNT) begin
            rptr   <= add_sum;
            copy_v <= 1'b1;
          end else begin
            copy_v <= 1'b0;
            state  <= S_FILL;
          end
        end
        S_FILL: begin
          if (int'(wptr) == tccw_pkg::CELL_COUNT - 1) begin
            state <= S_DONE;
          end
          wptr <= wptr + 1'b1;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // Latch the request and collect the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q         <= tccw_pkg::op_t'(opcode);
      ch_q         <= char_code;
      col_q        <= col;
      row_q        <= row;
      res_written  <= 1'b0;
      res_index    <= '0;
      res_entry    <= '0;
      res_scrolled <= 1'b0;
      res_read     <= '0;
    end else if (state == S_EXEC && op_q == tccw_pkg::OP_PUT) begin
      res_written  <= upd.written;
      res_index    <= upd.written ? tccw_pkg::POS_W'(add_sum) : '0;
      res_entry    <= upd.written ? {attr, ch_q} : '0;
      res_scrolled <= upd.scroll;
    end else if (state == S_READ) begin
      res_read <= rd_data;
    end
  end

  // Output register: load on the final step, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cursor_col   <= cur_col;
      cursor_row   <= cur_row;
      cursor_pos   <= tccw_pkg::POS_W'(add_sum);
      cell_written <= res_written;
      cell_index   <= res_index;
      cell_entry   <= res_entry;
      scrolled     <= res_scrolled;
      read_entry   <= res_read;
    end
  end

endmodule

/* tb/text_console_cell_writer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit_tb
// Self-checking bench for the text console: a local copy of the screen,
// cursor and attribute predicts every result, which is checked field by field
// against the result transfers. Directed control-character, wrap, scroll and
// range cases come first, then random traffic under several idling phases,
// a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 50;
  localparam int PHASE_ITEMS    = 270;

  typedef struct packed {
    logic [tccw_pkg::COL_W-1:0]   cur_col;
    logic [tccw_pkg::ROW_W-1:0]   cur_row;
    logic [tccw_pkg::POS_W-1:0]   pos;
    logic                         written;
    logic [tccw_pkg::POS_W-1:0]   index;
    logic [tccw_pkg::ENTRY_W-1:0] entry;
    logic                         scrolled;
    logic [tccw_pkg::ENTRY_W-1:0] read_value;
  } console_result_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    opcode = tccw_pkg::OP_PUT;
  logic [tccw_pkg::CHAR_W-1:0]   char_code = '0;
  logic [tccw_pkg::COL_W-1:0]    col = '0;
  logic [tccw_pkg::ROW_W-1:0]    row = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tccw_pkg::ATTR_W-1:0]   text_attribute = tccw_pkg::RESET_ATTR;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [tccw_pkg::COL_W-1:0]    cursor_col;
  logic [tccw_pkg::ROW_W-1:0]    cursor_row;
  logic [tccw_pkg::POS_W-1:0]    cursor_pos;
  logic                          cell_written;
  logic [tccw_pkg::POS_W-1:0]    cell_index;
  logic [tccw_pkg::ENTRY_W-1:0]  cell_entry;
  logic                          scrolled;
  logic [tccw_pkg::ENTRY_W-1:0]  read_entry;

  // Predicted console state
  logic [tccw_pkg::ENTRY_W-1:0]  screen_image [tccw_pkg::CELL_COUNT];
  int                            pred_col;
  int                            pred_row;
  logic [tccw_pkg::ATTR_W-1:0]   attr_now;

  console_result_t     pending_results [$];
  int                  failures = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  hold_request = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;

  text_console_cell_writer_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the predicted console and return its result
  function automatic console_result_t predict_console(tccw_pkg::op_t op,
                                                      logic [tccw_pkg::CHAR_W-1:0] ch,
                                                      logic [tccw_pkg::COL_W-1:0] c,
                                                      logic [tccw_pkg::ROW_W-1:0] r);
    console_result_t res;
    int idx;
    res = '0;
    unique case (op)
      tccw_pkg::OP_PUT: begin
        if (ch == tccw_pkg::CH_LF) begin
          pred_col = 0;
          pred_row++;
        end else if (ch == tccw_pkg::CH_CR) begin
          pred_col = 0;
        end else if (ch == tccw_pkg::CH_TAB) begin
          pred_col = (pred_col + 8) & ~7;
          if (pred_col >= tccw_pkg::COLUMNS) begin
            pred_col = 0;
            pred_row++;
          end
        end else if (ch == tccw_pkg::CH_BS) begin
          if (pred_col > 0) begin
            pred_col--;
          end else if (pred_row > 0) begin
            pred_row--;
            pred_col = tccw_pkg::COLUMNS - 1;
          end
        end else if (ch >= tccw_pkg::PRINT_LO && ch <= tccw_pkg::PRINT_HI) begin
          idx = pred_row * tccw_pkg::COLUMNS + pred_col;
          screen_image[idx] = {attr_now, ch};
          res.written = 1'b1;
          res.index = tccw_pkg::POS_W'(idx);
          res.entry = {attr_now, ch};
          pred_col++;
          if (pred_col >= tccw_pkg::COLUMNS) begin
            pred_col = 0;
            pred_row++;
          end
        end
        // Move rows up by one and blank the bottom row
        if (pred_row >= tccw_pkg::ROWS) begin
          for (int i = 0; i < tccw_pkg::FILL_BASE; i++)
            screen_image[i] = screen_image[i + tccw_pkg::COLUMNS];
          for (int i = tccw_pkg::FILL_BASE; i < tccw_pkg::CELL_COUNT; i++)
            screen_image[i] = {attr_now, tccw_pkg::BLANK_CHAR};
          pred_row = tccw_pkg::ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      tccw_pkg::OP_SET: begin
        if (c < tccw_pkg::COLUMNS && r < tccw_pkg::ROWS) begin
          pred_col = c;
          pred_row = r;
        end
      end
      tccw_pkg::OP_CLEAR: begin
        for (int i = 0; i < tccw_pkg::CELL_COUNT; i++)
          screen_image[i] = {attr_now, tccw_pkg::BLANK_CHAR};
        pred_col = 0;
        pred_row = 0;
      end
      default: begin
        if (c < tccw_pkg::COLUMNS && r < tccw_pkg::ROWS)
          res.read_value = screen_image[r * tccw_pkg::COLUMNS + c];
      end
    endcase
    res.cur_col = tccw_pkg::COL_W'(pred_col);
    res.cur_row = tccw_pkg::ROW_W'(pred_row);
    res.pos = tccw_pkg::POS_W'(pred_row * tccw_pkg::COLUMNS + pred_col);
    return res;
  endfunction

  // Offer one request after a random idle gap; leave valid high on return
  task automatic send_request(tccw_pkg::op_t op, logic [tccw_pkg::CHAR_W-1:0] ch,
                              logic [tccw_pkg::COL_W-1:0] c,
                              logic [tccw_pkg::ROW_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    char_code <= ch;
    col <= c;
    row <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_console(op, ch, c, r));
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_attribute(logic [tccw_pkg::ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    text_attribute <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    attr_now = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  // Mostly printable text and in-range cursor moves, some control and noise
  task automatic issue_random_request();
    int pick;
    tccw_pkg::op_t op;
    logic [tccw_pkg::CHAR_W-1:0] ch;
    logic [tccw_pkg::COL_W-1:0] c;
    logic [tccw_pkg::ROW_W-1:0] r;
    pick = $urandom_range(99);
    ch = tccw_pkg::CHAR_W'($urandom);
    c = tccw_pkg::COL_W'($urandom);
    r = tccw_pkg::ROW_W'($urandom);
    if (pick < 55) begin
      op = tccw_pkg::OP_PUT;
      pick = $urandom_range(99);
      if (pick < 70)
        ch = tccw_pkg::CHAR_W'($urandom_range(tccw_pkg::PRINT_HI, tccw_pkg::PRINT_LO));
      else if (pick < 74) ch = tccw_pkg::CH_LF;
      else if (pick < 78) ch = tccw_pkg::CH_CR;
      else if (pick < 84) ch = tccw_pkg::CH_TAB;
      else if (pick < 90) ch = tccw_pkg::CH_BS;
    end else if (pick < 70) begin
      op = tccw_pkg::OP_SET;
      pick = $urandom_range(99);
      if (pick < 85) begin
        c = tccw_pkg::COL_W'($urandom_range(tccw_pkg::COLUMNS - 1));
        // favor the bottom row so wraps and newlines scroll
        r = (pick < 20) ? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)
                        : tccw_pkg::ROW_W'($urandom_range(tccw_pkg::ROWS - 1));
      end
    end else if (pick < 72) begin
      op = tccw_pkg::OP_CLEAR;
    end else begin
      op = tccw_pkg::OP_READ;
      pick = $urandom_range(99);
      if (pick < 50) begin
        // read back around the cursor, where text was just written
        r = (pick < 25 && pred_row > 0) ? tccw_pkg::ROW_W'(pred_row - 1)
                                        : tccw_pkg::ROW_W'(pred_row);
        c = tccw_pkg::COL_W'($urandom_range(tccw_pkg::COLUMNS - 1));
      end else if (pick < 85) begin
        r = tccw_pkg::ROW_W'($urandom_range(tccw_pkg::ROWS - 1));
        c = tccw_pkg::COL_W'($urandom_range(tccw_pkg::COLUMNS - 1));
      end
    end
    send_request(op, ch, c, r);
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    send_request(tccw_pkg::OP_READ, 8'h00, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::PRINT_LO, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::PRINT_HI, 7'd0, 5'd0);
    // bytes outside the printable range are ignored
    send_request(tccw_pkg::OP_PUT, 8'h00, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, 8'h1F, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, 8'h80, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, 8'hFF, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_CR, 7'd0, 5'd0);
    // backspace at the top-left cell stays put
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
    // backspace at column 0 goes to the end of the row above
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 7'd0, 5'd0);
    // tab from the last stop wraps to the next row
    send_request(tccw_pkg::OP_SET, 8'h00, 7'd72, 5'd3);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
    // printable at the line end wraps
    send_request(tccw_pkg::OP_SET, 8'h00, tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1), 5'd2);
    send_request(tccw_pkg::OP_PUT, 8'h5A, 7'd0, 5'd0);
    // out-of-range cursor moves are ignored
    send_request(tccw_pkg::OP_SET, 8'h00, tccw_pkg::COL_W'(tccw_pkg::COLUMNS), 5'd0);
    send_request(tccw_pkg::OP_SET, 8'h00, 7'd0, tccw_pkg::ROW_W'(tccw_pkg::ROWS));
    send_request(tccw_pkg::OP_SET, 8'hFF, 7'h7F, 5'h1F);
    send_request(tccw_pkg::OP_READ, 8'h00, tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1), 5'd2);
    send_request(tccw_pkg::OP_READ, 8'h00, tccw_pkg::COL_W'(tccw_pkg::COLUMNS), 5'd0);
    send_request(tccw_pkg::OP_READ, 8'hFF, 7'h7F, 5'h1F);
    // scroll by wrap, by newline and by tab on the bottom row
    send_request(tccw_pkg::OP_SET, 8'h00, tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1),
                 tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
    send_request(tccw_pkg::OP_PUT, 8'h7E, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_SET, 8'h00, 7'd75, tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
    send_request(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(tccw_pkg::OP_READ, 8'h00, tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1),
                 tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
  endtask

  task automatic test_random_traffic(logic [tccw_pkg::ATTR_W-1:0] attr, int send_pct,
                                     int stall_pct);
    wait_for_results();
    write_attribute(attr);
    set_idling(send_pct, stall_pct);
    repeat (PHASE_ITEMS) issue_random_request();
  endtask

  // Hold the output off while requests keep coming so the input backs up
  task automatic test_output_hold_off();
    set_idling(0, 0);
    hold_request <= hold_request + 1;
    repeat (40) issue_random_request();
  endtask

  task automatic test_pause_until_drained();
    set_idling(10, 10);
    repeat (20) issue_random_request();
    wait_for_results();
    repeat (20) issue_random_request();
  endtask

  // Output side: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    console_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with no request outstanding", $time);
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("cursor_col", 16'(want.cur_col), 16'(cursor_col));
        compare_field("cursor_row", 16'(want.cur_row), 16'(cursor_row));
        compare_field("cursor_pos", 16'(want.pos), 16'(cursor_pos));
        compare_field("cell_written", 16'(want.written), 16'(cell_written));
        compare_field("cell_index", 16'(want.index), 16'(cell_index));
        compare_field("cell_entry", want.entry, cell_entry);
        compare_field("scrolled", 16'(want.scrolled), 16'(scrolled));
        compare_field("read_entry", want.read_value, read_entry);
      end
    end
  end

  // End the run when nothing has been transferred for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < tccw_pkg::CELL_COUNT; i++) screen_image[i] = tccw_pkg::RESET_ENTRY;
    pred_col = 0;
    pred_row = 0;
    attr_now = tccw_pkg::RESET_ATTR;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // attribute write lands during the clearing pass
    write_attribute(8'h1F);
    test_directed_cases();
    test_random_traffic(8'h00, 0, 0);
    test_random_traffic(8'hFF, 70, 0);
    test_random_traffic(tccw_pkg::ATTR_W'($urandom), 0, 70);
    test_random_traffic(tccw_pkg::ATTR_W'($urandom), 10, 10);
    test_output_hold_off();
    test_pause_until_drained();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
